### rtl/vva_pkg.sv
// Package for the four-component vector ALU: fixed-point widths, operation codes,
// payload words and the sideband struct carried down the pipeline.
// No dependencies.
`default_nettype none
package vva_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PW        = 66;
  localparam int SATW      = 68;
  localparam int SQW       = 68;
  localparam int RTW       = SQW / 2;
  localparam int REMW      = RTW + 2;
  localparam int QW        = FRAC_BITS + 1;
  localparam int DVW       = 32 + FRAC_BITS;
  localparam int DRW       = RTW + 1;

  typedef enum logic [3:0] {
    FN_SET   = 4'd0,
    FN_BCAST = 4'd1,
    FN_ADD   = 4'd2,
    FN_SUB   = 4'd3,
    FN_MUL   = 4'd4,
    FN_ADDS  = 4'd5,
    FN_SUBS  = 4'd6,
    FN_MULS  = 4'd7,
    FN_DOT   = 4'd8,
    FN_LEN   = 4'd9,
    FN_DIST  = 4'd10,
    FN_NORM  = 4'd11
  } func_t;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_LEN,
    KIND_NORM
  } kind_t;

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    logic [3:0]  func;
    logic        lerp_mode;
    fix_t        a_x;
    fix_t        a_y;
    fix_t        a_z;
    fix_t        a_w;
    fix_t        b_x;
    fix_t        b_y;
    fix_t        b_z;
    fix_t        b_w;
    fix_t        scalar_in;
  } in_word_t;

  typedef struct packed {
    fix_t        r_x;
    fix_t        r_y;
    fix_t        r_z;
    fix_t        r_w;
    fix_t        scalar_out;
    logic        zero_length;
    logic        saturated;
  } out_word_t;

  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [3:0][31:0] r;
    logic [31:0]     so;
    logic            sat;
    logic [3:0][31:0] a;
  } side_t;

  function automatic logic signed [SATW-1:0] sx(input logic [31:0] v);
    return {{(SATW-32){v[31]}}, v};
  endfunction

  // {clamped, value}
  function automatic logic [32:0] sat32(input logic [SATW-1:0] v);
    logic [32:0] res;
    if ((&v[SATW-1:31]) || (~|v[SATW-1:31])) res = {1'b0, v[31:0]};
    else if (v[SATW-1]) res = {1'b1, 32'h8000_0000};
    else res = {1'b1, 32'h7fff_ffff};
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/vec4_vector_alu_core.sv
// Top level of the four-component Q16.16 vector ALU: front end, square root,
// divider and output register. Depends on vva_pkg, vva_front, vva_sqrt, vva_div.
//
// One command word is taken in every clock (busy stays low) and its result word
// appears on out_data with out_valid high for exactly one cycle, in order, after
// passing the front end, the 34-stage square root (one root bit per stage), the
// 17-stage divider for normalize and the output register; every operation runs
// through the same path. The receiver cannot stall the block.
`default_nettype none
module vec4_vector_alu_core import vva_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_data,
  output logic          out_valid,
  output out_word_t     out_data
);

  side_t              front_side, sqrt_side, div_side;
  logic [SQW-1:0]     front_sumsq;
  logic [RTW-1:0]     sqrt_root, div_root;
  logic [3:0][QW-1:0] div_quo;

  logic               out_valid_r;
  out_word_t          out_data_r;
  out_word_t          out_nxt;

  assign busy = 1'b0;

  vva_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .in_data  (in_data),
    .o_side   (front_side),
    .o_sumsq  (front_sumsq)
  );

  vva_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_side (front_side),
    .i_rad  (front_sumsq),
    .o_side (sqrt_side),
    .o_root (sqrt_root)
  );

  vva_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_side (sqrt_side),
    .i_root (sqrt_root),
    .o_side (div_side),
    .o_root (div_root),
    .o_quo  (div_quo)
  );

  always_comb begin
    logic [31:0]     rv [4];
    logic [31:0]     qx;
    logic [31:0]     so;
    logic            sat;
    logic            zl;
    logic            rsat;
    logic [31:0]     rootv;
    rsat  = |div_root[RTW-1:31];
    rootv = rsat ? 32'h7fff_ffff : {1'b0, div_root[30:0]};
    so    = div_side.so;
    sat   = div_side.sat;
    zl    = 1'b0;
    for (int i = 0; i < 4; i++) rv[i] = div_side.r[i];
    unique case (div_side.kind)
      KIND_LEN: begin
        so  = rootv;
        sat = rsat;
      end
      KIND_NORM: begin
        if (div_root == '0) begin
          zl = 1'b1;
          so = '0;
          for (int i = 0; i < 4; i++) rv[i] = div_side.a[i];
        end else begin
          so  = rootv;
          sat = rsat;
          for (int i = 0; i < 4; i++) begin
            qx    = {{(32-QW){1'b0}}, div_quo[i]};
            rv[i] = div_side.a[i][31] ? (~qx + 32'd1) : qx;
          end
        end
      end
      default: ;
    endcase
    out_nxt.r_x         = rv[0];
    out_nxt.r_y         = rv[1];
    out_nxt.r_z         = rv[2];
    out_nxt.r_w         = rv[3];
    out_nxt.scalar_out  = so;
    out_nxt.zero_length = zl;
    out_nxt.saturated   = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= div_side.valid;
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### rtl/vva_front.sv
// Front end: operand select, per-lane multiply, and combine/saturate (three stages).
// Depends on vva_pkg.
`default_nettype none
module vva_front import vva_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire in_word_t        in_data,
  output side_t                o_side,
  output logic [SQW-1:0]       o_sumsq
);

  logic [31:0]        a_c [4];
  logic [31:0]        b_c [4];
  logic signed [32:0] d_c [4];
  logic signed [32:0] x_nxt [4];
  logic signed [32:0] y_nxt [4];

  logic               v1_r, v2_r;
  func_t              fn1_r, fn2_r;
  logic               lerp1_r, lerp2_r;
  logic [31:0]        a1_r [4];
  logic [31:0]        b1_r [4];
  logic [31:0]        s1_r, s2_r;
  logic [31:0]        a2_r [4];
  logic [31:0]        b2_r [4];
  logic signed [32:0] x1_r [4];
  logic signed [32:0] y1_r [4];
  logic signed [PW-1:0] p2_r [4];

  logic signed [PW-1:0]   fl [4];
  logic signed [SATW-1:0] flx [4];
  logic signed [SATW-1:0] w [4];
  logic signed [SATW-1:0] wso;
  logic [32:0]            rs [4];
  logic [32:0]            sos;
  logic [SQW-1:0]         sumsq_nxt;
  side_t                  side_nxt;
  side_t                  side3_r;
  logic [SQW-1:0]         sumsq3_r;

  assign a_c[0] = in_data.a_x;
  assign a_c[1] = in_data.a_y;
  assign a_c[2] = in_data.a_z;
  assign a_c[3] = in_data.a_w;
  assign b_c[0] = in_data.b_x;
  assign b_c[1] = in_data.b_y;
  assign b_c[2] = in_data.b_z;
  assign b_c[3] = in_data.b_w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_c[i]   = $signed({b_c[i][31], b_c[i]}) - $signed({a_c[i][31], a_c[i]});
      x_nxt[i] = $signed({a_c[i][31], a_c[i]});
      y_nxt[i] = $signed({b_c[i][31], b_c[i]});
      if (in_data.lerp_mode) begin
        x_nxt[i] = $signed({in_data.scalar_in[31], in_data.scalar_in});
        y_nxt[i] = d_c[i];
      end else begin
        unique case (in_data.func)
          FN_MULS: y_nxt[i] = $signed({in_data.scalar_in[31], in_data.scalar_in});
          FN_LEN, FN_NORM: y_nxt[i] = $signed({a_c[i][31], a_c[i]});
          FN_DIST: begin
            x_nxt[i] = d_c[i];
            y_nxt[i] = d_c[i];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    fn1_r   <= func_t'(in_data.func);
    lerp1_r <= in_data.lerp_mode;
    s1_r    <= in_data.scalar_in;
    fn2_r   <= fn1_r;
    lerp2_r <= lerp1_r;
    s2_r    <= s1_r;
    for (int i = 0; i < 4; i++) begin
      a1_r[i] <= a_c[i];
      b1_r[i] <= b_c[i];
      x1_r[i] <= x_nxt[i];
      y1_r[i] <= y_nxt[i];
      a2_r[i] <= a1_r[i];
      b2_r[i] <= b1_r[i];
      p2_r[i] <= x1_r[i] * y1_r[i];
    end
  end

  always_comb begin
    side_nxt       = '0;
    side_nxt.valid = v2_r;
    side_nxt.kind  = KIND_DIRECT;
    wso            = '0;
    sumsq_nxt      = '0;
    for (int i = 0; i < 4; i++) begin
      fl[i]     = p2_r[i] >>> FRAC_BITS;
      flx[i]    = {{(SATW-PW){fl[i][PW-1]}}, fl[i]};
      w[i]      = '0;
      sumsq_nxt = sumsq_nxt + {{(SQW-PW){1'b0}}, p2_r[i]};
    end
    if (lerp2_r) begin
      for (int i = 0; i < 4; i++) w[i] = flx[i] + sx(a2_r[i]);
    end else begin
      unique case (fn2_r)
        FN_SET:   for (int i = 0; i < 4; i++) w[i] = sx(b2_r[i]);
        FN_BCAST: for (int i = 0; i < 4; i++) w[i] = sx(s2_r);
        FN_ADD:   for (int i = 0; i < 4; i++) w[i] = sx(a2_r[i]) + sx(b2_r[i]);
        FN_SUB:   for (int i = 0; i < 4; i++) w[i] = sx(a2_r[i]) - sx(b2_r[i]);
        FN_ADDS:  for (int i = 0; i < 4; i++) w[i] = sx(a2_r[i]) + sx(s2_r);
        FN_SUBS:  for (int i = 0; i < 4; i++) w[i] = sx(a2_r[i]) - sx(s2_r);
        FN_MUL, FN_MULS: for (int i = 0; i < 4; i++) w[i] = flx[i];
        FN_DOT:   wso = flx[0] + flx[1] + flx[2] + flx[3];
        FN_LEN, FN_DIST: side_nxt.kind = KIND_LEN;
        FN_NORM:  side_nxt.kind = KIND_NORM;
        default: ;
      endcase
    end
    sos          = sat32(wso);
    side_nxt.so  = sos[31:0];
    side_nxt.sat = sos[32];
    for (int i = 0; i < 4; i++) begin
      rs[i]          = sat32(w[i]);
      side_nxt.r[i]  = rs[i][31:0];
      side_nxt.sat   = side_nxt.sat | rs[i][32];
      side_nxt.a[i]  = a2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) side3_r.valid <= 1'b0;
    else side3_r <= side_nxt;
    sumsq3_r <= sumsq_nxt;
  end

  assign o_side  = side3_r;
  assign o_sumsq = sumsq3_r;

endmodule
`default_nettype wire

### rtl/vva_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on vva_pkg.
`default_nettype none
module vva_sqrt import vva_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire side_t          i_side,
  input  wire logic [SQW-1:0] i_rad,
  output side_t               o_side,
  output logic [RTW-1:0]      o_root
);

  side_t            side_r [RTW];
  logic [SQW-1:0]   rad_r  [RTW];
  logic [REMW-1:0]  rem_r  [RTW];
  logic [RTW-1:0]   root_r [RTW];

  side_t            sd_in   [RTW];
  logic [SQW-1:0]   rad_in  [RTW];
  logic [REMW-1:0]  rem_in  [RTW];
  logic [RTW-1:0]   root_in [RTW];

  assign sd_in[0]   = i_side;
  assign rad_in[0]  = i_rad;
  assign rem_in[0]  = '0;
  assign root_in[0] = '0;

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [REMW-1:0] rin;
    logic [REMW-1:0] trial;

    if (k > 0) begin : g_link
      assign sd_in[k]   = side_r[k-1];
      assign rad_in[k]  = rad_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
    end

    assign rin   = {rem_in[k][REMW-3:0], rad_in[k][SQW-1:SQW-2]};
    assign trial = {root_in[k], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) side_r[k].valid <= 1'b0;
      else side_r[k] <= sd_in[k];
      rad_r[k] <= {rad_in[k][SQW-3:0], 2'b00};
      if (rin >= trial) begin
        rem_r[k]  <= rin - trial;
        root_r[k] <= {root_in[k][RTW-2:0], 1'b1};
      end else begin
        rem_r[k]  <= rin;
        root_r[k] <= {root_in[k][RTW-2:0], 1'b0};
      end
    end
  end

  assign o_side = side_r[RTW-1];
  assign o_root = root_r[RTW-1];

endmodule
`default_nettype wire

### rtl/vva_div.sv
// Pipelined four-lane restoring divider for normalize, one quotient bit per stage.
// Depends on vva_pkg.
`default_nettype none
module vva_div import vva_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire side_t             i_side,
  input  wire logic [RTW-1:0]    i_root,
  output side_t                  o_side,
  output logic [RTW-1:0]         o_root,
  output logic [3:0][QW-1:0]     o_quo
);

  side_t               side_r [QW];
  logic [RTW-1:0]      root_r [QW];
  logic [3:0][DRW-1:0] rem_r  [QW];
  logic [3:0][QW-1:0]  low_r  [QW];
  logic [3:0][QW-1:0]  q_r    [QW];

  side_t               sd_in   [QW];
  logic [RTW-1:0]      root_in [QW];
  logic [3:0][DRW-1:0] rem_in  [QW];
  logic [3:0][QW-1:0]  low_in  [QW];
  logic [3:0][QW-1:0]  q_in    [QW];

  logic [3:0][DRW-1:0] rem0;
  logic [3:0][QW-1:0]  low0;

  always_comb begin
    logic [31:0]     mag;
    logic [DVW-1:0]  dv;
    for (int i = 0; i < 4; i++) begin
      mag     = i_side.a[i][31] ? (~i_side.a[i] + 32'd1) : i_side.a[i];
      dv      = {mag, {FRAC_BITS{1'b0}}};
      rem0[i] = {{(DRW-(DVW-QW)){1'b0}}, dv[DVW-1:QW]};
      low0[i] = dv[QW-1:0];
    end
  end

  assign sd_in[0]   = i_side;
  assign root_in[0] = i_root;
  assign rem_in[0]  = rem0;
  assign low_in[0]  = low0;
  assign q_in[0]    = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign sd_in[k]   = side_r[k-1];
      assign root_in[k] = root_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign low_in[k]  = low_r[k-1];
      assign q_in[k]    = q_r[k-1];
    end

    always_ff @(posedge clk) begin
      logic [DRW-1:0] rin;
      if (!rst_n) side_r[k].valid <= 1'b0;
      else side_r[k] <= sd_in[k];
      root_r[k] <= root_in[k];
      for (int i = 0; i < 4; i++) begin
        rin = {rem_in[k][i][DRW-2:0], low_in[k][i][QW-1]};
        low_r[k][i] <= {low_in[k][i][QW-2:0], 1'b0};
        if (rin >= {1'b0, root_in[k]}) begin
          rem_r[k][i] <= rin - {1'b0, root_in[k]};
          q_r[k][i]   <= {q_in[k][i][QW-2:0], 1'b1};
        end else begin
          rem_r[k][i] <= rin;
          q_r[k][i]   <= {q_in[k][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign o_side = side_r[QW-1];
  assign o_root = root_r[QW-1];
  assign o_quo  = q_r[QW-1];

endmodule
`default_nettype wire

### tb/vec4_vector_alu_core_test.sv
// Self-checking testbench for vec4_vector_alu_core: directed table then random command words,
// each result word checked against a Q16.16 vector ALU predictor. Depends on vva_pkg.
`timescale 1ns / 100ps
`default_nettype none
module vec4_vector_alu_core_test;
  import vva_pkg::*;

  typedef struct {
    in_word_t  cmd;
    logic      has_exp;
    out_word_t exp;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      out_valid;
  out_word_t out_data;

  out_word_t pending_q[$];
  int        n_err;
  row_t      rows[$];

  vec4_vector_alu_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("vec4_vector_alu_core_test: FAIL");
    $finish;
  end

  function automatic longint clamp32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint x, longint y);
    return (x * y) >>> FRAC_BITS;
  endfunction

  function automatic longint root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint norm4(longint v[4]);
    longint unsigned m[4];
    longint unsigned sum, sq;
    bit ovf;
    sum = 0;
    ovf = 0;
    foreach (m[i]) begin
      m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > (64'd1 << 31)) return 64'sd1 << 32;
    end
    foreach (m[i]) begin
      sq = m[i] * m[i];
      if (sum > 64'hffff_ffff_ffff_ffff - sq) ovf = 1;
      sum += sq;
    end
    if (ovf) return 64'sd1 << 32;
    return root_floor(sum);
  endfunction

  function automatic out_word_t vec_alu_result(in_word_t c);
    longint a[4], b[4], r[4], d[4];
    longint s, so, acc, len;
    bit sat, zl;
    out_word_t o;
    a = '{longint'(c.a_x), longint'(c.a_y), longint'(c.a_z), longint'(c.a_w)};
    b = '{longint'(c.b_x), longint'(c.b_y), longint'(c.b_z), longint'(c.b_w)};
    s = longint'(c.scalar_in);
    r = '{0, 0, 0, 0};
    so = 0;
    sat = 0;
    zl = 0;
    if (c.lerp_mode) begin
      foreach (r[i]) r[i] = clamp32(fx_mul(s, b[i] - a[i]) + a[i], sat);
    end else begin
      case (c.func)
        FN_SET: r = b;
        FN_BCAST: foreach (r[i]) r[i] = s;
        FN_ADD: foreach (r[i]) r[i] = clamp32(a[i] + b[i], sat);
        FN_SUB: foreach (r[i]) r[i] = clamp32(a[i] - b[i], sat);
        FN_MUL: foreach (r[i]) r[i] = clamp32(fx_mul(a[i], b[i]), sat);
        FN_ADDS: foreach (r[i]) r[i] = clamp32(a[i] + s, sat);
        FN_SUBS: foreach (r[i]) r[i] = clamp32(a[i] - s, sat);
        FN_MULS: foreach (r[i]) r[i] = clamp32(fx_mul(a[i], s), sat);
        FN_DOT: begin
          acc = 0;
          foreach (a[i]) acc += fx_mul(a[i], b[i]);
          so = clamp32(acc, sat);
        end
        FN_LEN: so = clamp32(norm4(a), sat);
        FN_DIST: begin
          foreach (d[i]) d[i] = b[i] - a[i];
          so = clamp32(norm4(d), sat);
        end
        FN_NORM: begin
          len = norm4(a);
          if (len == 0) begin
            zl = 1;
            r = a;
          end else begin
            foreach (r[i]) r[i] = clamp32((a[i] <<< FRAC_BITS) / len, sat);
            so = clamp32(len, sat);
          end
        end
        default: ;
      endcase
    end
    o.r_x = r[0][31:0];
    o.r_y = r[1][31:0];
    o.r_z = r[2][31:0];
    o.r_w = r[3][31:0];
    o.scalar_out = so[31:0];
    o.zero_length = zl;
    o.saturated = sat;
    return o;
  endfunction

  function automatic fix_t rand_fix();
    case ($urandom_range(0, 5))
      0: return fix_t'($urandom);
      1: return fix_t'($urandom_range(0, 6)) <<< 16;
      2: return -(fix_t'($urandom_range(0, 6)) <<< 16);
      3: return fix_t'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
      4: return fix_t'($signed($urandom) >>> $urandom_range(0, 31));
      default: return fix_t'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic in_word_t rand_cmd();
    in_word_t c;
    c.func = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 8) c.func = 4'($urandom_range(FN_SET, FN_NORM));
    c.lerp_mode = ($urandom_range(0, 9) == 0);
    c.a_x = rand_fix();
    c.a_y = rand_fix();
    c.a_z = rand_fix();
    c.a_w = rand_fix();
    c.b_x = rand_fix();
    c.b_y = rand_fix();
    c.b_z = rand_fix();
    c.b_w = rand_fix();
    c.scalar_in = rand_fix();
    if ($urandom_range(0, 15) == 0) begin
      c.a_x = 0; c.a_y = 0; c.a_z = 0; c.a_w = 0;
    end
    return c;
  endfunction

  function automatic in_word_t mk(logic [3:0] f, logic lm, fix_t av, fix_t bv, fix_t s);
    in_word_t c;
    c.func = f;
    c.lerp_mode = lm;
    c.a_x = av; c.a_y = av; c.a_z = av; c.a_w = av;
    c.b_x = bv; c.b_y = bv; c.b_z = bv; c.b_w = bv;
    c.scalar_in = s;
    return c;
  endfunction

  function automatic out_word_t mo(fix_t r, fix_t so, logic zl, logic sat);
    out_word_t o;
    o.r_x = r; o.r_y = r; o.r_z = r; o.r_w = r;
    o.scalar_out = so;
    o.zero_length = zl;
    o.saturated = sat;
    return o;
  endfunction

  localparam fix_t MAXV = 32'h7fff_ffff;
  localparam fix_t MINV = 32'h8000_0000;
  localparam fix_t ONE  = 32'h0001_0000;

  task automatic add_row(in_word_t c, logic he, out_word_t e);
    row_t rw;
    rw.cmd = c;
    rw.has_exp = he;
    rw.exp = e;
    rows.push_back(rw);
  endtask

  task automatic send_word(in_word_t c);
    int idle;
    idle = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(vec_alu_result(c));
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result word %h", out_data);
      end else begin
        e = pending_q.pop_front();
        if (out_data !== e) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected %h actual %h", e, out_data);
        end
      end
    end
  end

  initial begin
    row_t rw;
    int wait_cnt;
    n_err = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    add_row(mk(FN_SET, 0, 0, MAXV, 0), 1, mo(MAXV, 0, 0, 0));
    add_row(mk(FN_BCAST, 0, 0, 0, MINV), 1, mo(MINV, 0, 0, 0));
    add_row(mk(FN_ADD, 0, MAXV, MAXV, 0), 1, mo(MAXV, 0, 0, 1));
    add_row(mk(FN_SUB, 0, MINV, MAXV, 0), 1, mo(MINV, 0, 0, 1));
    add_row(mk(FN_MUL, 0, ONE, ONE, 0), 1, mo(ONE, 0, 0, 0));
    add_row(mk(FN_MUL, 0, MINV, MINV, 0), 1, mo(MAXV, 0, 0, 1));
    add_row(mk(FN_ADDS, 0, MAXV, 0, ONE), 1, mo(MAXV, 0, 0, 1));
    add_row(mk(FN_SUBS, 0, MINV, 0, ONE), 1, mo(MINV, 0, 0, 1));
    add_row(mk(FN_MULS, 0, -ONE, 0, ONE), 1, mo(-ONE, 0, 0, 0));
    add_row(mk(FN_MULS, 0, -1, 0, 1), 1, mo(-1, 0, 0, 0));
    add_row(mk(FN_DOT, 0, ONE, ONE, 0), 1, mo(0, 4 * ONE, 0, 0));
    add_row(mk(FN_LEN, 0, ONE, 0, 0), 1, mo(0, 2 * ONE, 0, 0));
    add_row(mk(FN_LEN, 0, MINV, 0, 0), 0, mo(0, 0, 0, 0));
    add_row(mk(FN_DIST, 0, MINV, MAXV, 0), 1, mo(0, MAXV, 0, 1));
    add_row(mk(FN_NORM, 0, 0, ONE, ONE), 1, mo(0, 0, 1, 0));
    add_row(mk(FN_NORM, 0, ONE, 0, 0), 1, mo(ONE / 2, 2 * ONE, 0, 0));
    add_row(mk(FN_NORM, 0, MINV, 0, 0), 0, mo(0, 0, 0, 0));
    add_row(mk(FN_NORM, 0, 1, 0, 0), 0, mo(0, 0, 0, 0));
    add_row(mk(4'd12, 0, MAXV, MAXV, MAXV), 1, mo(0, 0, 0, 0));
    add_row(mk(4'd15, 0, MINV, MINV, MINV), 1, mo(0, 0, 0, 0));
    add_row(mk(FN_DOT, 1, 0, 2 * ONE, ONE / 2), 1, mo(ONE, 0, 0, 0));
    add_row(mk(FN_SET, 1, MINV, MAXV, MAXV), 1, mo(MAXV, 0, 0, 1));
    add_row(mk(4'd15, 1, MAXV, MINV, MINV), 0, mo(0, 0, 0, 0));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.has_exp && vec_alu_result(rw.cmd) !== rw.exp) begin
        n_err++;
        if (n_err <= 10)
          $display("table row %0d: expected %h predicted %h", i, rw.exp,
                   vec_alu_result(rw.cmd));
      end
      send_word(rw.cmd);
    end
    for (int k = 0; k < 1900; k++) begin
      if (k == 950) begin
        start <= 1'b0;
        wait_cnt = 0;
        do begin
          @(posedge clk);
          wait_cnt++;
        end while (pending_q.size() != 0 && wait_cnt < 1000);
      end
      if (k >= 1200 && k < 1400) begin
        start <= 1'b1;
        in_data <= rand_cmd();
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_q.push_back(vec_alu_result(in_data));
      end else begin
        send_word(rand_cmd());
      end
    end
    start <= 1'b0;
    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (60) @(posedge clk);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("vec4_vector_alu_core_test: PASS");
    end else begin
      $display("vec4_vector_alu_core_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
